// ===== hw/rtl/swqm_pkg.sv =====
// Shared types, constants and helpers for the sliding-window quality mask.
package swqm_pkg;

  // Field widths
  localparam int CHAR_W = 8;
  localparam int QUAL_W = 8;
  localparam int THR_W  = 12;
  localparam int SPAN_W = 5;
  // Window length lc + 1 + rc fits in one bit more than a span
  localparam int WIN_W  = SPAN_W + 1;
  // Sum of up to 63 qualities of 8 bits
  localparam int SUM_W  = 14;

  // Defaults for the top-level parameters
  localparam int MAX_SPAN_DEF   = 31;
  localparam int RING_DEPTH_DEF = 64;

  // Command queue between front and back
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int FIFO_LVL_W     = $clog2(CMD_FIFO_DEPTH + 1);
  // In-flight results: queue entries, one in the back, one in the output register
  localparam int OUT_W          = $clog2(CMD_FIFO_DEPTH + 3);

  localparam logic [THR_W-1:0]  THR_RESET = 12'd320;
  localparam logic [CHAR_W-1:0] MASK_CHAR = 8'h4E;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_LEFT_SPAN  = 2'd1,
    CFG_RIGHT_SPAN = 2'd2
  } cfg_reg_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DRAIN,
    BK_RESULT
  } back_state_e;

  // One emit command: window clip on each side and end-of-read flag
  typedef struct packed {
    logic [SPAN_W-1:0] lc;
    logic [SPAN_W-1:0] rc;
    logic              last;
  } cmd_t;

  // Largest usable span so that a window always fits the ring
  function automatic int span_limit(input int max_span, input int ring_depth);
    int half;
    half = (ring_depth - 2) >> 1;
    return (max_span < half) ? max_span : half;
  endfunction

endpackage

// ===== hw/rtl/swqm_ring.sv =====
// Base and quality ring buffer: one write port, one registered read port.
module swqm_ring import swqm_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  localparam int PtrW = $clog2(RING_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [PtrW-1:0]   waddr_i,
  input  logic [CHAR_W-1:0] wbase_i,
  input  logic [QUAL_W-1:0] wqual_i,
  input  logic              ren_i,
  input  logic [PtrW-1:0]   raddr_i,
  output logic [CHAR_W-1:0] rbase_o,
  output logic [QUAL_W-1:0] rqual_o
);

  logic [CHAR_W+QUAL_W-1:0] mem_q [RING_DEPTH];
  logic [CHAR_W+QUAL_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wbase_i, wqual_i};
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (ren_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rbase_o = rdata_q[CHAR_W+QUAL_W-1:QUAL_W];
  assign rqual_o = rdata_q[QUAL_W-1:0];

endmodule

// ===== hw/rtl/swqm_front.sv =====
// Front end: accepts bases into the ring and issues one emit command per result.
module swqm_front import swqm_pkg::*; #(
  parameter int MAX_SPAN   = MAX_SPAN_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  localparam int PtrW = $clog2(RING_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CHAR_W-1:0] in_base_i,
  input  logic [QUAL_W-1:0] in_qual_i,
  input  logic              in_last_i,
  // configuration
  input  logic [SPAN_W-1:0] left_span_i,
  input  logic [SPAN_W-1:0] right_span_i,
  // ring write port
  output logic              ring_we_o,
  output logic [PtrW-1:0]   ring_waddr_o,
  output logic [CHAR_W-1:0] ring_wbase_o,
  output logic [QUAL_W-1:0] ring_wqual_o,
  // command queue
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o,
  // result delivered at the output
  input  logic              out_done_i,
  output logic [OUT_W-1:0]  outstanding_o
);

  localparam int SpanLimit   = span_limit(MAX_SPAN, RING_DEPTH);
  localparam int BefW        = $clog2(SpanLimit + 1);
  // Pending plus in-flight bases that still leave the oldest window intact
  localparam int AcceptLimit = RING_DEPTH - 1 - SpanLimit;
  localparam logic [PtrW-1:0] WpLast = PtrW'(RING_DEPTH - 1);
  localparam logic [BefW-1:0] BefMax = BefW'(SpanLimit);

  logic [PtrW-1:0]   wp_q, wp_d;
  logic [PtrW-1:0]   pending_q, pending_d;
  logic [BefW-1:0]   before_q, before_d;
  logic              flush_q, flush_d;
  logic [OUT_W-1:0]  outst_q, outst_d;

  logic [SPAN_W-1:0] ls_eff, rs_eff;
  logic              accept, emit_want, emit, emit_last;
  cmd_t              cmd;

  // Spans clamped so a window fits the ring
  assign ls_eff = (int'(left_span_i) > SpanLimit) ? SPAN_W'(SpanLimit) : left_span_i;
  assign rs_eff = (int'(right_span_i) > SpanLimit) ? SPAN_W'(SpanLimit) : right_span_i;

  // Input handshake: held during a flush and while the ring has no room
  assign in_ready_o = !flush_q && ((int'(pending_q) + int'(outst_q)) <= AcceptLimit);
  assign accept     = in_valid_i && in_ready_o;

  // Emit decision for the oldest pending base
  always_comb begin
    if (flush_q) begin
      emit_want = (pending_q != '0);
    end else begin
      emit_want = (int'(pending_q) > int'(rs_eff));
    end
    emit      = emit_want && cmd_ready_i;
    emit_last = flush_q && (pending_q == PtrW'(1));
  end

  // Window clip for the command
  always_comb begin
    cmd.lc   = (int'(before_q) < int'(ls_eff)) ? SPAN_W'(before_q) : ls_eff;
    cmd.rc   = ((int'(pending_q) - 1) < int'(rs_eff)) ? SPAN_W'(pending_q - PtrW'(1))
                                                      : rs_eff;
    cmd.last = emit_last;
  end

  assign cmd_valid_o = emit_want;
  assign cmd_o       = cmd;

  // Ring write
  assign ring_we_o    = accept;
  assign ring_waddr_o = wp_q;
  assign ring_wbase_o = in_base_i;
  assign ring_wqual_o = in_qual_i;

  // Counters and flush flag
  always_comb begin
    wp_d      = wp_q;
    pending_d = pending_q;
    before_d  = before_q;
    flush_d   = flush_q;
    outst_d   = outst_q;
    if (accept) begin
      wp_d = (wp_q == WpLast) ? '0 : wp_q + PtrW'(1);
      if (in_last_i) begin
        flush_d = 1'b1;
      end
    end
    pending_d = pending_q + PtrW'(accept) - PtrW'(emit);
    if (emit) begin
      if (emit_last) begin
        before_d = '0;
        flush_d  = 1'b0;
      end else if (before_q != BefMax) begin
        before_d = before_q + BefW'(1);
      end
    end
    outst_d = outst_q + OUT_W'(emit) - OUT_W'(out_done_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      pending_q <= '0;
      before_q  <= '0;
      flush_q   <= 1'b0;
      outst_q   <= '0;
    end else begin
      wp_q      <= wp_d;
      pending_q <= pending_d;
      before_q  <= before_d;
      flush_q   <= flush_d;
      outst_q   <= outst_d;
    end
  end

  assign outstanding_o = outst_q;

endmodule

// ===== hw/rtl/swqm_cmd_fifo.sv =====
// Small command queue between front end and back end.
module swqm_cmd_fifo import swqm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  cmd_t                  push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output cmd_t                  pop_data_o,
  output logic [FIFO_LVL_W-1:0] level_o
);

  localparam int IdxW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam logic [IdxW-1:0]       IdxLast = IdxW'(CMD_FIFO_DEPTH - 1);
  localparam logic [FIFO_LVL_W-1:0] LvlFull = FIFO_LVL_W'(CMD_FIFO_DEPTH);

  cmd_t                  slot_q [CMD_FIFO_DEPTH];
  logic [IdxW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_LVL_W-1:0] lvl_q, lvl_d;
  logic                  push, pop;

  assign push_ready_o = (lvl_q != LvlFull);
  assign pop_valid_o  = (lvl_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_q];
  assign level_o      = lvl_q;

  // Pointer and level update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push) begin
      wr_d = (wr_q == IdxLast) ? '0 : wr_q + IdxW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == IdxLast) ? '0 : rd_q + IdxW'(1);
    end
    lvl_d = lvl_q + FIFO_LVL_W'(push) - FIFO_LVL_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/swqm_back.sv =====
// Back end: sums each window from the ring, compares, and holds the result.
module swqm_back import swqm_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  localparam int PtrW = $clog2(RING_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [THR_W-1:0]  threshold_i,
  // command queue
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  // ring read port
  output logic              ring_ren_o,
  output logic [PtrW-1:0]   ring_raddr_o,
  input  logic [CHAR_W-1:0] ring_rbase_i,
  input  logic [QUAL_W-1:0] ring_rqual_i,
  // result
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] out_base_o,
  output logic              out_masked_o,
  output logic              out_last_o,
  output logic              busy_o
);

  localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_DEPTH - 1);
  localparam int ProdW = THR_W + WIN_W;

  back_state_e       state_q, state_d;
  logic [PtrW-1:0]   pos_q, pos_d;
  logic [PtrW-1:0]   addr_q, addr_d;
  logic [WIN_W-1:0]  idx_q, idx_d;
  logic [WIN_W-1:0]  count_q, count_d;
  logic [SPAN_W-1:0] lc_q, lc_d;
  logic              last_q, last_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CHAR_W-1:0] base_q, base_d;
  logic              rd_vld_q, rd_ctr_q, rd_ctr_d;

  logic              out_valid_q;
  logic [CHAR_W-1:0] out_base_q;
  logic              out_masked_q, out_last_q;

  logic              out_free, take_cmd, load_out, read_end, low;
  logic [PtrW-1:0]   start_addr;
  logic [ProdW-1:0]  prod, scaled;

  assign out_free = !out_valid_q || out_ready_i;
  assign read_end = (idx_q == count_q - WIN_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:   if (cmd_valid_i) state_d = BK_READ;
      BK_READ:   if (read_end) state_d = BK_DRAIN;
      BK_DRAIN:  state_d = BK_RESULT;
      BK_RESULT: if (out_free) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    take_cmd   = 1'b0;
    ring_ren_o = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      BK_IDLE:   take_cmd = cmd_valid_i;
      BK_READ:   ring_ren_o = 1'b1;
      BK_DRAIN:  ;
      BK_RESULT: load_out = out_free;
      default:   ;
    endcase
  end

  assign cmd_ready_o  = (state_q == BK_IDLE);
  assign ring_raddr_o = addr_q;
  assign busy_o       = (state_q != BK_IDLE);

  // First ring entry of the window, wrapped
  always_comb begin
    if (int'(pos_q) >= int'(cmd_i.lc)) begin
      start_addr = PtrW'(int'(pos_q) - int'(cmd_i.lc));
    end else begin
      start_addr = PtrW'(int'(pos_q) + RING_DEPTH - int'(cmd_i.lc));
    end
  end

  // Window walk and accumulation
  always_comb begin
    pos_d    = pos_q;
    addr_d   = addr_q;
    idx_d    = idx_q;
    count_d  = count_q;
    lc_d     = lc_q;
    last_d   = last_q;
    sum_d    = sum_q;
    base_d   = base_q;
    rd_ctr_d = (idx_q == WIN_W'(lc_q));
    if (take_cmd) begin
      pos_d   = (pos_q == PtrLast) ? '0 : pos_q + PtrW'(1);
      addr_d  = start_addr;
      idx_d   = '0;
      count_d = WIN_W'(cmd_i.lc) + WIN_W'(cmd_i.rc) + WIN_W'(1);
      lc_d    = cmd_i.lc;
      last_d  = cmd_i.last;
      sum_d   = '0;
    end
    if (ring_ren_o) begin
      addr_d = (addr_q == PtrLast) ? '0 : addr_q + PtrW'(1);
      idx_d  = idx_q + WIN_W'(1);
    end
    if (rd_vld_q) begin
      sum_d = sum_q + SUM_W'(ring_rqual_i);
      if (rd_ctr_q) begin
        base_d = ring_rbase_i;
      end
    end
  end

  // Mean test: sum*16 < threshold*count
  always_comb begin
    prod   = ProdW'(threshold_i) * ProdW'(count_q);
    scaled = {sum_q, 4'b0000};
    low    = (scaled < prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      pos_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      rd_vld_q <= ring_ren_o;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    idx_q    <= idx_d;
    count_q  <= count_d;
    lc_q     <= lc_d;
    last_q   <= last_d;
    sum_q    <= sum_d;
    base_q   <= base_d;
    rd_ctr_q <= rd_ctr_d;
    if (load_out) begin
      out_base_q   <= low ? MASK_CHAR : base_q;
      out_masked_q <= low;
      out_last_q   <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_base_o   = out_base_q;
  assign out_masked_o = out_masked_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== hw/rtl/sliding_window_quality_mask.sv =====
// Top level of the sliding-window mean quality mask.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------------
//  s_axis   | in        | tvalid / tready       | tdata: base_char, quality; tlast
//  m_axis   | out       | tvalid / tready       | tdata: base_out; tuser: masked; tlast
//  cfg      | in        | cfg_valid / cfg_ready | cfg_addr: register, cfg_data
//
// Inputs are taken one per cycle into the ring as long as the pending bases plus
// results in flight stay within RING_DEPTH-1 minus the span limit; after a last
// input the port is held until every flush command is queued.
// The back end walks each window (window_length = lc + 1 + rc, at most 63) through
// the single ring read port and takes no new command until its result is loaded.
// Reset clears control state only; the ring holds no valid bits and needs no clear.
// A stall at the output stops the back end once its result register is full.
module sliding_window_quality_mask import swqm_pkg::*; #(
  parameter int MAX_SPAN   = MAX_SPAN_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] base_char, [15:8] quality
  input  logic        s_axis_tlast_i,   // last_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] base_out
  output logic        m_axis_tuser_o,   // [0] masked
  output logic        m_axis_tlast_o,   // last_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [11:0] cfg_data_i
);

  localparam int PtrW = $clog2(RING_DEPTH);

  logic [THR_W-1:0]      thr_q;
  logic [SPAN_W-1:0]     ls_q, rs_q;

  logic                  ring_we, ring_ren;
  logic [PtrW-1:0]       ring_waddr, ring_raddr;
  logic [CHAR_W-1:0]     ring_wbase, ring_rbase;
  logic [QUAL_W-1:0]     ring_wqual, ring_rqual;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  cmd_t                  push_cmd, pop_cmd;
  logic [FIFO_LVL_W-1:0] fifo_level;
  logic [OUT_W-1:0]      outstanding;
  logic                  back_busy;

  logic [CHAR_W-1:0]     out_base;
  logic                  out_masked, out_done;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      ls_q  <= '0;
      rs_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_THRESHOLD:  thr_q <= cfg_data_i;
        CFG_LEFT_SPAN:  ls_q  <= cfg_data_i[SPAN_W-1:0];
        CFG_RIGHT_SPAN: rs_q  <= cfg_data_i[SPAN_W-1:0];
        default:        ;
      endcase
    end
  end

  swqm_front #(
    .MAX_SPAN   (MAX_SPAN),
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_base_i     (s_axis_tdata_i[7:0]),
    .in_qual_i     (s_axis_tdata_i[15:8]),
    .in_last_i     (s_axis_tlast_i),
    .left_span_i   (ls_q),
    .right_span_i  (rs_q),
    .ring_we_o     (ring_we),
    .ring_waddr_o  (ring_waddr),
    .ring_wbase_o  (ring_wbase),
    .ring_wqual_o  (ring_wqual),
    .cmd_valid_o   (push_valid),
    .cmd_ready_i   (push_ready),
    .cmd_o         (push_cmd),
    .out_done_i    (out_done),
    .outstanding_o (outstanding)
  );

  swqm_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wbase_i (ring_wbase),
    .wqual_i (ring_wqual),
    .ren_i   (ring_ren),
    .raddr_i (ring_raddr),
    .rbase_o (ring_rbase),
    .rqual_o (ring_rqual)
  );

  swqm_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_cmd),
    .level_o      (fifo_level)
  );

  swqm_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .threshold_i  (thr_q),
    .cmd_valid_i  (pop_valid),
    .cmd_ready_o  (pop_ready),
    .cmd_i        (pop_cmd),
    .ring_ren_o   (ring_ren),
    .ring_raddr_o (ring_raddr),
    .ring_rbase_i (ring_rbase),
    .ring_rqual_i (ring_rqual),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_base_o   (out_base),
    .out_masked_o (out_masked),
    .out_last_o   (m_axis_tlast_o),
    .busy_o       (back_busy)
  );

  // Output packing
  assign out_done       = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tdata_o = out_base;
  assign m_axis_tuser_o = out_masked;

  // In-flight count must match queue, back end and output register
  a_inflight_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(outstanding) == int'(fifo_level) + int'(back_busy) + int'(m_axis_tvalid_o))
    else $error("in-flight count out of step with queue and back end");

  // A last input starts a flush that holds the input port
  a_flush_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("input taken right after end of read");

  // A masked result always carries the mask character
  a_masked_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == MASK_CHAR))
    else $error("masked result without mask character");

endmodule
